// ===== design/kmp_pkg.sv =====
// Shared types and constants for the keypad matrix port.
package kmp_pkg;

   localparam int NUM_COLUMNS = 4;
   localparam int NUM_ROWS    = 5;

   localparam logic [NUM_ROWS-1:0] ROW_MASK = '1;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_KEY   = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   localparam logic [1:0] HW_CTRL = 2'd0;
   localparam logic [1:0] HW_STAT = 2'd1;
   localparam logic [1:0] HW_DDR  = 2'd2;
   localparam logic [1:0] HW_DATA = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [3:0]  reg_offset;
      logic [1:0]  access_size;
      logic [31:0] write_data;
      logic [2:0]  key_column;
      logic [2:0]  key_row;
      logic        key_pressed;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_level;
      logic        access_error;
   } rsp_type;

endpackage

// ===== design/kmp_regs.sv =====
// Register file, key matrix and per-item result logic of the keypad port.
module kmp_regs
   import kmp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   output rsp_type result
);

   logic [15:0]         control_ff, control_in;
   logic [15:0]         ddr_ff, ddr_in;
   logic [7:0]          drive_ff, drive_in;
   logic [1:0]          flags_ff, flags_in;
   logic [1:0]          enables_ff, enables_in;
   logic [NUM_ROWS-1:0] keys_ff [NUM_COLUMNS];
   logic [NUM_ROWS-1:0] keys_in [NUM_COLUMNS];

   logic [NUM_ROWS-1:0] rows;
   logic [15:0]         data_view;
   logic [15:0]         stat_view;
   logic [1:0]          idx;
   logic [1:0]          idx_hi;
   logic                access_ok;
   logic                is_access;
   logic [15:0]         half_lo;
   logic [15:0]         half_hi;
   logic [15:0]         merged;
   logic [3:0]          we;
   logic [15:0]         wv [4];
   logic                key_hit;
   logic                key_now;
   logic                any_key;
   logic [1:0]          flags_wr;

   function automatic logic [15:0] read_half(input logic [1:0] sel,
                                             input logic [15:0] ctrl,
                                             input logic [15:0] stat,
                                             input logic [15:0] ddr,
                                             input logic [15:0] data);
      logic [15:0] v;
      case (sel)
         HW_CTRL: v = ctrl;
         HW_STAT: v = stat;
         HW_DDR:  v = ddr;
         default: v = data;
      endcase
      return v;
   endfunction

   always_comb begin
      rows = ROW_MASK;
      for (int c = 0; c < NUM_COLUMNS; c++) begin
         if (!drive_ff[c]) begin
            rows = rows & ~keys_ff[c];
         end
      end
      any_key = 1'b0;
      for (int c = 0; c < NUM_COLUMNS; c++) begin
         any_key = any_key | (|keys_ff[c]);
      end
   end

   assign data_view = {drive_ff, 8'(rows)};
   assign stat_view = {6'b0, enables_ff, 6'b0, flags_ff};

   assign idx    = item.reg_offset[2:1];
   assign idx_hi = idx + 2'd1;
   assign is_access = (item.operation == OP_READ) || (item.operation == OP_WRITE);

   always_comb begin
      case (item.access_size)
         SIZE_BYTE: access_ok = !item.reg_offset[3];
         SIZE_HALF: access_ok = !item.reg_offset[3] && !item.reg_offset[0];
         SIZE_WORD: access_ok = !item.reg_offset[3] && !item.reg_offset[0] && (idx != 2'd3);
         default:   access_ok = 1'b0;
      endcase
   end

   assign half_lo = read_half(idx, control_ff, stat_view, ddr_ff, data_view);
   assign half_hi = read_half(idx_hi, control_ff, stat_view, ddr_ff, data_view);
   assign merged  = item.reg_offset[0] ? {item.write_data[7:0], half_lo[7:0]}
                                       : {half_lo[15:8], item.write_data[7:0]};

   always_comb begin
      we = '0;
      for (int i = 0; i < 4; i++) begin
         wv[i] = item.write_data[15:0];
      end
      if (item.operation == OP_WRITE && access_ok) begin
         case (item.access_size)
            SIZE_BYTE: begin
               we[idx] = 1'b1;
               wv[idx] = merged;
            end
            SIZE_HALF: begin
               we[idx] = 1'b1;
            end
            default: begin
               we[idx]    = 1'b1;
               we[idx_hi] = 1'b1;
               wv[idx_hi] = item.write_data[31:16];
            end
         endcase
      end
   end

   always_comb begin
      key_hit = ({1'b0, item.key_column} < 4'(NUM_COLUMNS))
             && ({1'b0, item.key_row} < 4'(NUM_ROWS));
      key_now = 1'b0;
      for (int c = 0; c < NUM_COLUMNS; c++) begin
         keys_in[c] = keys_ff[c];
         for (int r = 0; r < NUM_ROWS; r++) begin
            if (item.key_column == 3'(c) && item.key_row == 3'(r)) begin
               key_now = keys_ff[c][r];
               if (item.operation == OP_KEY) begin
                  keys_in[c][r] = item.key_pressed;
               end
            end
         end
      end

      control_in = we[HW_CTRL] ? wv[HW_CTRL] : control_ff;
      ddr_in     = we[HW_DDR] ? wv[HW_DDR] : ddr_ff;
      drive_in   = we[HW_DATA] ? wv[HW_DATA][15:8] : drive_ff;
      enables_in = we[HW_STAT] ? wv[HW_STAT][9:8] : enables_ff;
      flags_wr   = we[HW_STAT] ? (flags_ff & ~wv[HW_STAT][1:0]) : flags_ff;

      case (item.operation)
         OP_KEY: begin
            flags_in = flags_ff;
            if (key_hit && key_now != item.key_pressed) begin
               flags_in = item.key_pressed ? (flags_ff | 2'b01) : (flags_ff | 2'b10);
            end
         end
         OP_TICK: begin
            flags_in = (any_key && enables_ff[0]) ? (flags_ff | 2'b01) : flags_ff;
         end
         default: begin
            flags_in = flags_wr;
         end
      endcase
   end

   always_comb begin
      result.read_data    = '0;
      result.access_error = is_access && !access_ok;
      result.irq_level    = |(flags_in & enables_in);
      if (item.operation == OP_READ && access_ok) begin
         case (item.access_size)
            SIZE_BYTE: result.read_data = {24'b0, item.reg_offset[0] ? half_lo[15:8]
                                                                     : half_lo[7:0]};
            SIZE_HALF: result.read_data = {16'b0, half_lo};
            default:   result.read_data = {half_hi, half_lo};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff <= '0;
         ddr_ff     <= '0;
         drive_ff   <= '0;
         flags_ff   <= '0;
         enables_ff <= '0;
         for (int c = 0; c < NUM_COLUMNS; c++) begin
            keys_ff[c] <= '0;
         end
      end else if (fire) begin
         control_ff <= control_in;
         ddr_ff     <= ddr_in;
         drive_ff   <= drive_in;
         flags_ff   <= flags_in;
         enables_ff <= enables_in;
         for (int c = 0; c < NUM_COLUMNS; c++) begin
            keys_ff[c] <= keys_in[c];
         end
      end
   end

endmodule

// ===== design/keypad_matrix_port_unit.sv =====
// Top level of the keypad matrix port: input register, register file and result register.
//
//   channel  direction  payload   transfer when
//   req      in         req_type  req_valid && req_ready
//   rsp      out        rsp_type  rsp_valid && rsp_ready
//
// From request transfer to result valid, each item sits in the input register while the
// register file logic forms its result, which the result register takes once it is free or its result is taken.
// One item is accepted every cycle while results are taken.
// Synchronous reset clears the valid bits, the port registers, flags, enables and the key matrix.
// A stalled result holds its register; the input register still takes one more item if empty.
module keypad_matrix_port_unit
   import kmp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   req_type in_ff;
   logic    in_valid_ff;
   rsp_type out_ff;
   logic    out_valid_ff;
   rsp_type result;
   logic    advance;
   logic    fire;

   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   kmp_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_payload;
      end
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

// ===== dv/keypad_matrix_port_unit_tb.sv =====
// Self-checking testbench for the keypad matrix port: a directed table, then random traffic.
module keypad_matrix_port_unit_tb;
   import kmp_pkg::*;

   localparam logic [3:0] OFF_CTRL = 4'h0;
   localparam logic [3:0] OFF_STAT = 4'h2;
   localparam logic [3:0] OFF_DDR  = 4'h4;
   localparam logic [3:0] OFF_DATA = 4'h6;

   localparam int DIRECTED_ROWS = 26;
   localparam int RANDOM_ITEMS  = 1180;
   localparam int BURST_FIRST   = 200;
   localparam int BURST_LAST    = 500;
   localparam int DRAIN_AT      = 700;
   localparam int LONG_HOLD     = 80;
   localparam int IDLE_LIMIT    = 1000;

   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type answer;
   } directed_row_t;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   logic    row_typed = 1'b0;
   rsp_type row_answer = '0;

   logic [15:0]         ctrl_reg;
   logic [15:0]         ddr_reg;
   logic [7:0]          col_drive;
   logic [1:0]          flags;
   logic [1:0]          enables;
   logic [NUM_ROWS-1:0] key_state [NUM_COLUMNS];

   rsp_type       pending_port_results [$];
   int            mismatch_count = 0;
   int            idle_cycles = 0;
   directed_row_t directed_rows [DIRECTED_ROWS];

   keypad_matrix_port_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   function automatic bit is_register(input logic [4:0] off);
      return off < 5'd8 && !off[0];
   endfunction

   function automatic logic [15:0] visible_half(input logic [1:0] hw);
      logic [NUM_ROWS-1:0] rows;
      rows = ROW_MASK;
      for (int c = 0; c < NUM_COLUMNS; c++)
         if (!col_drive[c]) rows &= ~key_state[c];
      case (hw)
         HW_CTRL: return ctrl_reg;
         HW_STAT: return {6'b0, enables, 6'b0, flags};
         HW_DDR:  return ddr_reg;
         default: return {col_drive, 8'(rows)};
      endcase
   endfunction

   function automatic void store_half(input logic [1:0] hw, input logic [15:0] v);
      case (hw)
         HW_CTRL: ctrl_reg = v;
         HW_STAT: begin
            flags   = flags & ~v[1:0];
            enables = v[9:8];
         end
         HW_DDR:  ddr_reg = v;
         default: col_drive = v[15:8];
      endcase
   endfunction

   function automatic void clear_port_state();
      ctrl_reg  = '0;
      ddr_reg   = '0;
      col_drive = '0;
      flags     = '0;
      enables   = '0;
      for (int c = 0; c < NUM_COLUMNS; c++) key_state[c] = '0;
   endfunction

   function automatic rsp_type predict_port_response(input req_type r);
      rsp_type     o;
      logic [4:0]  base;
      logic [1:0]  hw;
      logic [15:0] v;
      bit          ok;
      bit          held;
      o    = '0;
      ok   = 1'b1;
      base = (r.access_size == SIZE_BYTE) ? {1'b0, r.reg_offset[3:1], 1'b0}
                                          : {1'b0, r.reg_offset};
      hw   = base[2:1];
      case (r.operation)
         OP_READ, OP_WRITE: begin
            case (r.access_size)
               SIZE_BYTE, SIZE_HALF: ok = is_register(base);
               SIZE_WORD: ok = is_register(base) && is_register(base + 5'd2);
               default: ok = 1'b0;
            endcase
            if (ok && r.operation == OP_READ) begin
               v = visible_half(hw);
               case (r.access_size)
                  SIZE_BYTE: o.read_data = r.reg_offset[0] ? 32'(v[15:8]) : 32'(v[7:0]);
                  SIZE_HALF: o.read_data = 32'(v);
                  default:   o.read_data = {visible_half(hw + 2'd1), v};
               endcase
            end else if (ok) begin
               case (r.access_size)
                  SIZE_BYTE: begin
                     v = visible_half(hw);
                     if (r.reg_offset[0]) v[15:8] = r.write_data[7:0];
                     else v[7:0] = r.write_data[7:0];
                     store_half(hw, v);
                  end
                  SIZE_HALF: store_half(hw, r.write_data[15:0]);
                  default: begin
                     store_half(hw, r.write_data[15:0]);
                     store_half(hw + 2'd1, r.write_data[31:16]);
                  end
               endcase
            end
         end
         OP_KEY: begin
            if (r.key_column < NUM_COLUMNS && r.key_row < NUM_ROWS &&
                key_state[r.key_column[1:0]][r.key_row] != r.key_pressed) begin
               key_state[r.key_column[1:0]][r.key_row] = r.key_pressed;
               if (r.key_pressed) flags[0] = 1'b1;
               else flags[1] = 1'b1;
            end
         end
         default: begin
            held = 1'b0;
            for (int c = 0; c < NUM_COLUMNS; c++)
               if (key_state[c] != '0) held = 1'b1;
            if (held && enables[0]) flags[0] = 1'b1;
         end
      endcase
      o.irq_level    = |(flags & enables);
      o.access_error = !ok;
      return o;
   endfunction

   function automatic req_type make_req(input logic [1:0] op, input logic [3:0] off,
                                        input logic [1:0] size, input logic [31:0] wd,
                                        input logic [2:0] col, input logic [2:0] row,
                                        input logic pressed);
      req_type r;
      r.operation   = op;
      r.reg_offset  = off;
      r.access_size = size;
      r.write_data  = wd;
      r.key_column  = col;
      r.key_row     = row;
      r.key_pressed = pressed;
      return r;
   endfunction

   function automatic req_type make_random_req();
      req_type     r;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      r.operation   = roll < 35 ? OP_READ : roll < 65 ? OP_WRITE : roll < 90 ? OP_KEY : OP_TICK;
      r.reg_offset  = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 7))
                                                    : 4'($urandom_range(8, 15));
      r.access_size = ($urandom_range(0, 99) < 90) ? 2'($urandom_range(0, 2)) : 2'd3;
      r.write_data  = $urandom;
      r.key_column  = ($urandom_range(0, 99) < 90) ? 3'($urandom_range(0, NUM_COLUMNS - 1))
                                                    : 3'($urandom_range(NUM_COLUMNS, 7));
      r.key_row     = ($urandom_range(0, 99) < 90) ? 3'($urandom_range(0, NUM_ROWS - 1))
                                                    : 3'($urandom_range(NUM_ROWS, 7));
      r.key_pressed = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   task automatic send_item(input req_type item, input logic typed, input rsp_type answer,
                            input int unsigned gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      row_typed   <= typed;
      row_answer  <= answer;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_port_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : port_checker
      rsp_type want;
      rsp_type predicted;
      if (reset) begin
         clear_port_state();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_port_results.size() == 0) begin
               $error("response transfer with no request outstanding");
               mismatch_count++;
            end else begin
               want = pending_port_results.pop_front();
               if (rsp_payload.read_data !== want.read_data) begin
                  $error("read_data: expected %h, got %h", want.read_data, rsp_payload.read_data);
                  mismatch_count++;
               end
               if (rsp_payload.irq_level !== want.irq_level) begin
                  $error("irq_level: expected %b, got %b", want.irq_level, rsp_payload.irq_level);
                  mismatch_count++;
               end
               if (rsp_payload.access_error !== want.access_error) begin
                  $error("access_error: expected %b, got %b", want.access_error,
                         rsp_payload.access_error);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predicted = predict_port_response(req_payload);
            pending_port_results.push_back(row_typed ? row_answer : predicted);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : response_sink
      int          stall_left;
      int          taken;
      bit          held_long;
      int unsigned roll;
      stall_left = 0;
      taken      = 0;
      held_long  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) taken++;
         if (!held_long && taken >= 250) begin
            held_long  = 1'b1;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (taken >= 600 && taken < 800) begin
            rsp_ready <= 1'b1;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready  <= 1'b0;
               stall_left = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 25);
            end
         end
      end
   end

   initial begin : stimulus
      directed_rows = '{
         {make_req(OP_READ,  OFF_CTRL, SIZE_HALF, 32'h0, 3'd0, 3'd0, 1'b0), 1'b1,
          32'h0000_0000, 1'b0, 1'b0},
         {make_req(OP_READ,  OFF_DATA, SIZE_HALF, 32'h0, 3'd0, 3'd0, 1'b0), 1'b1,
          32'h0000_001F, 1'b0, 1'b0},
         {make_req(OP_READ,  4'h8, SIZE_HALF, 32'h0, 3'd0, 3'd0, 1'b0), 1'b1,
          32'h0, 1'b0, 1'b1},
         {make_req(OP_READ,  OFF_CTRL, 2'd3, 32'h0, 3'd0, 3'd0, 1'b0), 1'b1,
          32'h0, 1'b0, 1'b1},
         {make_req(OP_READ,  OFF_DATA, SIZE_WORD, 32'h0, 3'd0, 3'd0, 1'b0), 1'b1,
          32'h0, 1'b0, 1'b1},
         {make_req(OP_WRITE, 4'h3, SIZE_HALF, 32'hFFFF_FFFF, 3'd7, 3'd7, 1'b1), 1'b1,
          32'h0, 1'b0, 1'b1},
         {make_req(OP_WRITE, 4'hF, SIZE_WORD, 32'hFFFF_FFFF, 3'd7, 3'd7, 1'b1), 1'b1,
          32'h0, 1'b0, 1'b1},
         {make_req(OP_READ,  4'h9, SIZE_BYTE, 32'h0, 3'd0, 3'd0, 1'b0), 1'b1,
          32'h0, 1'b0, 1'b1},
         {make_req(OP_WRITE, OFF_CTRL, SIZE_WORD, 32'hFFFF_FFFF, 3'd0, 3'd0, 1'b0), 1'b0, 34'h0},
         {make_req(OP_WRITE, OFF_DDR,  SIZE_WORD, 32'hA5A5_5A5A, 3'd0, 3'd0, 1'b0), 1'b0, 34'h0},
         {make_req(OP_READ,  OFF_CTRL, SIZE_WORD, 32'h0, 3'd0, 3'd0, 1'b0), 1'b0, 34'h0},
         {make_req(OP_READ,  OFF_DDR,  SIZE_WORD, 32'h0, 3'd0, 3'd0, 1'b0), 1'b0, 34'h0},
         {make_req(OP_KEY,   OFF_CTRL, SIZE_BYTE, 32'h0, 3'd0, 3'd0, 1'b1), 1'b0, 34'h0},
         {make_req(OP_KEY,   OFF_CTRL, SIZE_BYTE, 32'h0, 3'd3, 3'd4, 1'b1), 1'b0, 34'h0},
         {make_req(OP_KEY,   OFF_CTRL, SIZE_BYTE, 32'h0, 3'd0, 3'd0, 1'b1), 1'b0, 34'h0},
         {make_req(OP_KEY,   OFF_CTRL, SIZE_BYTE, 32'h0, 3'd4, 3'd0, 1'b1), 1'b0, 34'h0},
         {make_req(OP_KEY,   OFF_CTRL, SIZE_BYTE, 32'h0, 3'd7, 3'd7, 1'b0), 1'b0, 34'h0},
         {make_req(OP_KEY,   OFF_CTRL, SIZE_BYTE, 32'h0, 3'd0, 3'd5, 1'b1), 1'b0, 34'h0},
         {make_req(OP_READ,  OFF_DATA, SIZE_BYTE, 32'h0, 3'd0, 3'd0, 1'b0), 1'b0, 34'h0},
         {make_req(OP_WRITE, OFF_STAT, SIZE_BYTE, 32'h0000_0003, 3'd0, 3'd0, 1'b0), 1'b0, 34'h0},
         {make_req(OP_TICK,  OFF_CTRL, SIZE_BYTE, 32'h0, 3'd0, 3'd0, 1'b0), 1'b0, 34'h0},
         {make_req(OP_WRITE, 4'h3, SIZE_BYTE, 32'h0000_0001, 3'd0, 3'd0, 1'b0), 1'b0, 34'h0},
         {make_req(OP_KEY,   OFF_CTRL, SIZE_BYTE, 32'h0, 3'd3, 3'd4, 1'b0), 1'b0, 34'h0},
         {make_req(OP_TICK,  OFF_CTRL, SIZE_BYTE, 32'h0, 3'd0, 3'd0, 1'b0), 1'b0, 34'h0},
         {make_req(OP_WRITE, OFF_DATA, SIZE_HALF, 32'h0000_0000, 3'd0, 3'd0, 1'b0), 1'b0, 34'h0},
         {make_req(OP_READ,  OFF_DATA, SIZE_HALF, 32'h0, 3'd0, 3'd0, 1'b0), 1'b0, 34'h0}
      };
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].answer,
                   pick_gap());
      wait_for_drain();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == DRAIN_AT) wait_for_drain();
         send_item(make_random_req(), 1'b0, '0,
                   (i >= BURST_FIRST && i < BURST_LAST) ? 0 : pick_gap());
      end
      wait_for_drain();
      repeat (10) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/kmp_pkg.sv
design/kmp_regs.sv
design/keypad_matrix_port_unit.sv
dv/keypad_matrix_port_unit_tb.sv
